// ===== rtl/assert_macros.svh =====
// Assertion macros used by the checker file of the project
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is low
`define SKI_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("sorted key intersection check failed");

// Next-cycle implication, disabled while reset is low
`define SKI_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("sorted key intersection check failed");

`endif

// ===== rtl/ski_pkg.sv =====
// Types and constants of the sorted key intersection block
package ski_pkg;

    localparam int KEY_W       = 32;
    localparam int VALUE_W     = 64;
    localparam int MODE_W      = 2;
    localparam int MAX_RESULTS = 32;
    // match counter saturates at MAX_RESULTS + 1
    localparam int RES_W       = $clog2(MAX_RESULTS + 2);

    localparam logic [MODE_W-1:0] MODE_LOAD_FIRST  = 2'd0;
    localparam logic [MODE_W-1:0] MODE_LOAD_SECOND = 2'd1;
    localparam logic [MODE_W-1:0] MODE_RUN         = 2'd2;
    // spare code, ignored by the block
    localparam logic [MODE_W-1:0] MODE_UNUSED      = 2'd3;

    typedef struct packed {
        logic [MODE_W-1:0]  mode;
        logic [KEY_W-1:0]   key;
        logic [VALUE_W-1:0] value;
    } t_in_item;

    typedef struct packed {
        logic [KEY_W-1:0]   match_key;
        logic [VALUE_W-1:0] first_value;
        logic [VALUE_W-1:0] second_value;
        logic               matched;
        logic               last;
        logic               truncated;
    } t_out_item;

    // controller to datapath
    typedef struct packed {
        logic load_first;
        logic load_second;
        logic start;
        logic rewind;
        logic step;
        logic pass2;
        logic emit_marker;
        logic finish;
    } t_dp_cmd;

    // datapath to controller
    typedef struct packed {
        logic exhausted;
        logic key_eq;
        logic last_match;
        logic total_zero;
        logic out_free;
    } t_dp_status;

endpackage

// ===== rtl/ski_ram.sv =====
// Generic single-write, single-read RAM with registered read data
module ski_ram #(
    parameter int WIDTH  = 96,
    parameter int DEPTH  = 32,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic [WIDTH-1:0]  i_wdata,
    input  logic [ADDR_W-1:0] i_raddr,
    output logic [WIDTH-1:0]  o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/ski_ctrl.sv =====
// Control state machine: load, count pass, emit pass, empty marker
module ski_ctrl (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    input  logic [ski_pkg::MODE_W-1:0]    i_mode,
    input  ski_pkg::t_dp_status           i_status,
    output ski_pkg::t_dp_cmd              o_cmd,
    output logic                          o_stall
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_PASS1,
        S_PASS2,
        S_MARKER
    } t_state;

    t_state           r_state;
    t_state           n_state;
    logic             r_busy;
    ski_pkg::t_dp_cmd cmd;

    // next state and command decode
    always_comb begin
        cmd     = '0;
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    case (i_mode)
                        ski_pkg::MODE_LOAD_FIRST:  cmd.load_first  = 1'b1;
                        ski_pkg::MODE_LOAD_SECOND: cmd.load_second = 1'b1;
                        ski_pkg::MODE_RUN: begin
                            cmd.start  = 1'b1;
                            cmd.rewind = 1'b1;
                            n_state    = S_PASS1;
                        end
                        default: ;
                    endcase
                end
            end
            // count matches without emitting
            S_PASS1: begin
                if (i_status.exhausted) begin
                    if (i_status.total_zero) begin
                        n_state = S_MARKER;
                    end else begin
                        cmd.rewind = 1'b1;
                        n_state    = S_PASS2;
                    end
                end else begin
                    cmd.step = 1'b1;
                end
            end
            // walk again and emit, one step whenever the output register can take it
            S_PASS2: begin
                if (i_status.exhausted) begin
                    cmd.finish = 1'b1;
                    n_state    = S_IDLE;
                end else if (i_status.out_free) begin
                    cmd.step  = 1'b1;
                    cmd.pass2 = 1'b1;
                    if (i_status.key_eq && i_status.last_match) begin
                        cmd.finish = 1'b1;
                        n_state    = S_IDLE;
                    end
                end
            end
            S_MARKER: begin
                if (i_status.out_free) begin
                    cmd.emit_marker = 1'b1;
                    cmd.finish      = 1'b1;
                    n_state         = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_busy  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_busy  <= (n_state != S_IDLE);
        end
    end

    assign o_cmd   = cmd;
    assign o_stall = r_busy;

endmodule

// ===== rtl/ski_datapath.sv =====
// Datapath: list stores, walk pointers, match counters and output register
module ski_datapath #(
    parameter int LIST_DEPTH = 32
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  ski_pkg::t_dp_cmd      i_cmd,
    input  logic [ski_pkg::KEY_W-1:0]   i_key,
    input  logic [ski_pkg::VALUE_W-1:0] i_value,
    input  logic                  i_stall,
    output ski_pkg::t_dp_status   o_status,
    output logic                  o_valid,
    output ski_pkg::t_out_item    o_data
);

    localparam int AW      = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;
    localparam int CW      = $clog2(LIST_DEPTH + 1);
    localparam int ENTRY_W = ski_pkg::KEY_W + ski_pkg::VALUE_W;
    localparam int RW      = ski_pkg::RES_W;

    logic [CW-1:0]      r_cnt1, r_cnt2;
    logic [CW-1:0]      r_p1, r_p2, n_p1, n_p2;
    logic               r_ovf, r_trunc;
    logic [RW-1:0]      r_total, r_limit, r_emit_cnt;
    logic               r_out_valid;
    ski_pkg::t_out_item r_out;

    logic [ENTRY_W-1:0]             rd1, rd2;
    logic [ski_pkg::KEY_W-1:0]      key1, key2;
    logic [ski_pkg::VALUE_W-1:0]    val1, val2;
    logic                           full1, full2, we1, we2;
    logic                           exhausted, key_eq, key_lt, last_match;
    logic                           emit_match, out_free, total_over;

    // list stores: key in the upper bits, value below
    assign full1 = (r_cnt1 == CW'(LIST_DEPTH));
    assign full2 = (r_cnt2 == CW'(LIST_DEPTH));
    assign we1   = i_cmd.load_first && !full1;
    assign we2   = i_cmd.load_second && !full2;

    ski_ram #(.WIDTH(ENTRY_W), .DEPTH(LIST_DEPTH)) u_ram_first (
        .i_clk   (i_clk),
        .i_we    (we1),
        .i_waddr (r_cnt1[AW-1:0]),
        .i_wdata ({i_key, i_value}),
        .i_raddr (n_p1[AW-1:0]),
        .o_rdata (rd1)
    );

    ski_ram #(.WIDTH(ENTRY_W), .DEPTH(LIST_DEPTH)) u_ram_second (
        .i_clk   (i_clk),
        .i_we    (we2),
        .i_waddr (r_cnt2[AW-1:0]),
        .i_wdata ({i_key, i_value}),
        .i_raddr (n_p2[AW-1:0]),
        .o_rdata (rd2)
    );

    assign key1 = rd1[ENTRY_W-1 -: ski_pkg::KEY_W];
    assign val1 = rd1[ski_pkg::VALUE_W-1:0];
    assign key2 = rd2[ENTRY_W-1 -: ski_pkg::KEY_W];
    assign val2 = rd2[ski_pkg::VALUE_W-1:0];

    // compare of the entries under both pointers
    assign exhausted  = (r_p1 >= r_cnt1) || (r_p2 >= r_cnt2);
    assign key_eq     = (key1 == key2);
    assign key_lt     = (key1 < key2);
    assign last_match = ((r_emit_cnt + RW'(1)) == r_limit);
    assign emit_match = i_cmd.step && i_cmd.pass2 && !exhausted && key_eq;
    assign out_free   = !r_out_valid || !i_stall;
    assign total_over = (r_total > RW'(ski_pkg::MAX_RESULTS));

    // pointer advance; the RAMs read at the next pointer so data lines up
    always_comb begin
        n_p1 = r_p1;
        n_p2 = r_p2;
        if (i_cmd.rewind) begin
            n_p1 = '0;
            n_p2 = '0;
        end else if (i_cmd.step && !exhausted) begin
            if (key_lt || key_eq) begin
                n_p1 = r_p1 + CW'(1);
            end
            if (!key_lt) begin
                n_p2 = r_p2 + CW'(1);
            end
        end
    end

    // list counts, overflow and run bookkeeping
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt1     <= '0;
            r_cnt2     <= '0;
            r_ovf      <= 1'b0;
            r_trunc    <= 1'b0;
            r_p1       <= '0;
            r_p2       <= '0;
            r_total    <= '0;
            r_limit    <= '0;
            r_emit_cnt <= '0;
        end else begin
            r_p1 <= n_p1;
            r_p2 <= n_p2;
            if (we1) begin
                r_cnt1 <= r_cnt1 + CW'(1);
            end
            if (we2) begin
                r_cnt2 <= r_cnt2 + CW'(1);
            end
            if ((i_cmd.load_first && full1) || (i_cmd.load_second && full2)) begin
                r_ovf <= 1'b1;
            end
            if (i_cmd.start) begin
                r_trunc <= r_ovf;
                r_ovf   <= 1'b0;
                r_total <= '0;
            end else if (i_cmd.rewind) begin
                // end of count pass: clip to the result slots
                r_limit    <= total_over ? RW'(ski_pkg::MAX_RESULTS) : r_total;
                r_trunc    <= r_trunc | total_over;
                r_emit_cnt <= '0;
            end
            if (i_cmd.step && !i_cmd.pass2 && !exhausted && key_eq &&
                r_total != RW'(ski_pkg::MAX_RESULTS + 1)) begin
                r_total <= r_total + RW'(1);
            end
            if (emit_match) begin
                r_emit_cnt <= r_emit_cnt + RW'(1);
            end
            if (i_cmd.finish) begin
                r_cnt1 <= '0;
                r_cnt2 <= '0;
            end
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (emit_match || i_cmd.emit_marker) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit_match) begin
            r_out.match_key    <= key1;
            r_out.first_value  <= val1;
            r_out.second_value <= val2;
            r_out.matched      <= 1'b1;
            r_out.last         <= last_match;
            r_out.truncated    <= r_trunc;
        end else if (i_cmd.emit_marker) begin
            r_out.match_key    <= '0;
            r_out.first_value  <= '0;
            r_out.second_value <= '0;
            r_out.matched      <= 1'b0;
            r_out.last         <= 1'b1;
            r_out.truncated    <= r_trunc;
        end
    end

    assign o_status.exhausted  = exhausted;
    assign o_status.key_eq     = key_eq;
    assign o_status.last_match = last_match;
    assign o_status.total_zero = (r_total == '0);
    assign o_status.out_free   = out_free;
    assign o_valid             = r_out_valid;
    assign o_data              = r_out;

endmodule

// ===== rtl/sorted_key_intersection_core.sv =====
// Sorted key intersection: loads two ascending (key, value) lists one entry per
// transaction (mode 0 first list, mode 1 second list, mode 3 ignored) and, on a run
// transaction (mode 2), merge-joins them with two pointers, returning one result per
// common key in ascending order with the last one marked, or a single unmatched
// marker when nothing matches. Each list holds LIST_DEPTH entries; extra loads are
// dropped and reported through truncated, as are matches beyond 32 results. Loads
// do not stall the input. A run makes a counting walk, then an emitting walk or, when
// nothing matched, the unmatched marker; both walks advance one step per cycle, set
// by the single read port of each list RAM, the emitting walk only while the output
// register is free. Input stall is high for the whole run.
// Both lists are empty again after a run. No clearing pass follows reset.
module sorted_key_intersection_core #(
    parameter int LIST_DEPTH = 32
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_stall,
    input  ski_pkg::t_in_item  i_data,
    output logic               o_valid,
    input  logic               i_stall,
    output ski_pkg::t_out_item o_data
);

    ski_pkg::t_dp_cmd    cmd;
    ski_pkg::t_dp_status status;

    ski_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .i_mode   (i_data.mode),
        .i_status (status),
        .o_cmd    (cmd),
        .o_stall  (o_stall)
    );

    ski_datapath #(.LIST_DEPTH(LIST_DEPTH)) u_datapath (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cmd    (cmd),
        .i_key    (i_data.key),
        .i_value  (i_data.value),
        .i_stall  (i_stall),
        .o_status (status),
        .o_valid  (o_valid),
        .o_data   (o_data)
    );

endmodule

// ===== rtl/ski_checker.sv =====
// Port-level checks for the sorted key intersection core, bound to the top level
`include "assert_macros.svh"

module ski_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_valid,
    input logic               o_stall,
    input ski_pkg::t_in_item  i_data,
    input logic               o_valid,
    input logic               i_stall,
    input ski_pkg::t_out_item o_data
);

    logic run_accept;
    logic marker_ok;

    assign run_accept = i_valid && !o_stall && (i_data.mode == ski_pkg::MODE_RUN);
    assign marker_ok  = o_data.last && (o_data.match_key == '0);

    // a stalled result transaction holds
    `SKI_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_valid && i_stall, o_valid && $stable(o_data))

    // the empty marker is always the last result and carries zero key
    `SKI_ASSERT_IMP(a_marker_last, i_clk, i_rst_n, o_valid && !o_data.matched, marker_ok)

    // while results of a run are still pending the input side stays stalled
    `SKI_ASSERT_IMP(a_run_busy, i_clk, i_rst_n, o_valid && !o_data.last, o_stall)

    // an accepted run transaction stalls the input next cycle
    `SKI_ASSERT_NEXT(a_run_stall, i_clk, i_rst_n, run_accept, o_stall)

endmodule

bind sorted_key_intersection_core ski_checker u_ski_checker (.*);
